FILE: design/lrip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrip_pkg
// Shared constants, types and tables of the lidar range image projection.
// ----------------------------------------------------------------------------
package lrip_pkg;

   localparam int DEG90        = 23040;
   localparam int DEG180       = 46080;
   localparam int DEG360       = 92160;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_IN_W    = 40;
   localparam int SQRT_OUT_W   = 20;

   localparam logic [2:0] CSR_ROW_COUNT    = 3'd0;
   localparam logic [2:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [2:0] CSR_ANGLE_TOP    = 3'd2;
   localparam logic [2:0] CSR_ANGLE_BOTTOM = 3'd3;
   localparam logic [2:0] CSR_MIN_RANGE    = 3'd4;

   localparam logic [6:0]  RST_ROW_COUNT    = 7'd16;
   localparam logic [11:0] RST_COLUMN_COUNT = 12'd1800;
   localparam logic [14:0] RST_ANGLE_TOP    = 15'd3840;
   localparam logic [14:0] RST_ANGLE_BOTTOM = 15'd3840;
   localparam logic [19:0] RST_MIN_RANGE    = 20'd100;

   typedef struct packed {
      logic signed [39:0] x;
      logic signed [39:0] y;
      logic signed [24:0] z;
      logic               num_neg;
      logic               den_neg;
   } cordic_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic [21:0] atan_entry(input int step);
      logic [21:0] v;
      case (step)
         0: v = 22'd2949120;
         1: v = 22'd1740967;
         2: v = 22'd919879;
         3: v = 22'd466945;
         4: v = 22'd234379;
         5: v = 22'd117304;
         6: v = 22'd58666;
         7: v = 22'd29335;
         8: v = 22'd14668;
         9: v = 22'd7334;
         10: v = 22'd3667;
         11: v = 22'd1833;
         12: v = 22'd917;
         13: v = 22'd458;
         14: v = 22'd229;
         15: v = 22'd115;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   function automatic int div_width(input int max_rows, input int max_cols);
      int rw;
      int cw;
      rw = $clog2(max_rows + 1);
      cw = $clog2(max_cols + 1);
      return ((16 + rw) > (18 + cw)) ? (16 + rw) : (18 + cw);
   endfunction

   function automatic int latency(input int max_rows, input int max_cols);
      return 3 + SQRT_OUT_W + 1 + CORDIC_STEPS + 3 + div_width(max_rows, max_cols) + 2;
   endfunction

endpackage
`default_nettype wire

FILE: design/lrip_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrip_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lrip_isqrt (
   input  logic                                clock,
   input  logic [lrip_pkg::SQRT_IN_W-1:0]      radicand,
   output logic [lrip_pkg::SQRT_OUT_W-1:0]     root
);

   localparam int STEPS = lrip_pkg::SQRT_OUT_W;
   localparam int IN_W  = lrip_pkg::SQRT_IN_W;
   localparam int REM_W = STEPS + 2;

   logic [REM_W-1:0] rem_ff  [0:STEPS-1];
   logic [REM_W-1:0] rem_in  [0:STEPS-1];
   logic [STEPS-1:0] root_ff [0:STEPS-1];
   logic [STEPS-1:0] root_in [0:STEPS-1];
   logic [IN_W-1:0]  rad_ff  [0:STEPS-1];
   logic [IN_W-1:0]  rad_in  [0:STEPS-1];

   always_comb begin
      logic [REM_W-1:0] rp;
      logic [STEPS-1:0] op;
      logic [IN_W-1:0]  dp;
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            rp = '0;
            op = '0;
            dp = radicand;
         end else begin
            rp = rem_ff[k-1];
            op = root_ff[k-1];
            dp = rad_ff[k-1];
         end
         cur   = {rp, dp[IN_W-1 -: 2]};
         trial = {2'b00, op, 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = REM_W'(cur - trial);
            root_in[k] = {op[STEPS-2:0], 1'b1};
         end else begin
            rem_in[k]  = REM_W'(cur);
            root_in[k] = {op[STEPS-2:0], 1'b0};
         end
         rad_in[k] = {dp[IN_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign root = root_ff[STEPS-1];

endmodule
`default_nettype wire

FILE: design/lrip_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrip_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lrip_div #(
   parameter int N = 30,
   parameter int D = 17
) (
   input  logic         clock,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic [N-1:0] quotient
);

   logic [D-1:0] rem_ff [0:N-1];
   logic [D-1:0] rem_in [0:N-1];
   logic [N-1:0] num_ff [0:N-1];
   logic [N-1:0] num_in [0:N-1];
   logic [D-1:0] dvs_ff [0:N-1];
   logic [D-1:0] dvs_in [0:N-1];

   always_comb begin
      logic [D-1:0] rp;
      logic [N-1:0] np;
      logic [D-1:0] dp;
      logic [D:0]   cur;
      logic         ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            rp = '0;
            np = dividend;
            dp = divisor;
         end else begin
            rp = rem_ff[k-1];
            np = num_ff[k-1];
            dp = dvs_ff[k-1];
         end
         cur = {rp, np[N-1]};
         ge  = (cur >= {1'b0, dp});
         rem_in[k] = ge ? D'(cur - {1'b0, dp}) : D'(cur);
         num_in[k] = {np[N-2:0], ge};
         dvs_in[k] = dp;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = num_ff[N-1];

endmodule
`default_nettype wire

FILE: design/lidar_range_image_projection_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_range_image_projection_top
// Projects one lidar point per cycle onto a range image cell.
// Path from start to rsp_strobe: the 20-stage square root, 16-stage CORDIC and
//   pipelined restoring row divider.
// Throughput: one point per cycle; busy is high only during reset.
// Reset: clears the pipeline valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module lidar_range_image_projection_top #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [19:0] req_point_x,
   input  logic signed [19:0] req_point_y,
   input  logic signed [19:0] req_point_z,
   output logic               rsp_strobe,
   output logic               rsp_valid_res,
   output logic [5:0]         rsp_row,
   output logic [10:0]        rsp_column,
   output logic [19:0]        rsp_range_mm,
   output logic [16:0]        rsp_pixel_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_data
);

   localparam int RW     = $clog2(MAX_ROWS + 1);
   localparam int CW     = $clog2(MAX_COLUMNS + 1);
   localparam int DW     = lrip_pkg::div_width(MAX_ROWS, MAX_COLUMNS);
   localparam int PR     = 18 + RW;
   localparam int PC     = 19 + CW;
   localparam int PXW    = RW + CW + 1;
   localparam int S_IN   = 1;
   localparam int S_SQ   = 2;
   localparam int S_SUM  = 3;
   localparam int S_ROOT = S_SUM + lrip_pkg::SQRT_OUT_W;
   localparam int S_CENT = S_ROOT + 1;
   localparam int S_CEND = S_CENT + lrip_pkg::CORDIC_STEPS;
   localparam int S_ANG  = S_CEND + 1;
   localparam int S_PROD = S_ANG + 1;
   localparam int S_DIN  = S_PROD + 1;
   localparam int S_DOUT = S_DIN + DW;
   localparam int S_POST = S_DOUT + 1;
   localparam int S_OUT  = S_POST + 1;
   localparam logic signed [24:0] Z_MAX = 25'(lrip_pkg::DEG90 * 256);
   localparam logic [16:0] COL_RECIP    = 17'd93207;
   localparam int          COL_RECIP_SH = 22;

   // configuration
   logic [6:0]  row_count_ff;
   logic [11:0] column_count_ff;
   logic [14:0] angle_top_ff;
   logic [14:0] angle_bottom_ff;
   logic [19:0] min_range_ff;
   logic [RW-1:0] rows_c;
   logic [CW-1:0] cols_c;
   logic [15:0]   span;

   // pipeline
   logic [S_OUT:1]     vld_ff;
   logic               accept;
   logic signed [19:0] px_ff [S_IN:S_ROOT];
   logic signed [19:0] py_ff [S_IN:S_ROOT];
   logic signed [19:0] pz_ff [S_IN:S_ROOT];
   logic [39:0]        xx_ff, yy_ff, zz_ff;
   logic [39:0]        hxy_ff, hxyz_ff;
   logic [19:0]        rxy;
   logic [19:0]        rng_root;
   logic [19:0]        rng_ff [S_CENT:S_OUT];

   lrip_pkg::cordic_type entry   [0:1];
   lrip_pkg::cordic_type cord_ff [0:1][S_CENT:S_CEND];
   lrip_pkg::cordic_type cord_in [0:1][S_CENT:S_CEND];
   logic signed [16:0]   ang_in  [0:1];
   logic signed [16:0]   ang_ff  [0:1];

   logic signed [PR-1:0] rnum_in, rnum_ff;
   logic signed [PC-1:0] cnum_in, cnum_ff;
   logic [DW-1:0]        rmag_in, rmag_ff;
   logic [DW-1:0]        cmag_in, cmag_ff;
   logic [16:0]          rdiv_ff;
   logic                 rneg_ff [S_DIN:S_DOUT];
   logic                 cneg_ff [S_DIN:S_DOUT];
   logic                 den0_ff [S_DIN:S_DOUT];
   logic [DW-1:0]        cquo_in;
   logic [DW-1:0]        cq_ff [S_DIN+1:S_DOUT];
   logic [DW-1:0]        rq, cq;

   logic                 post_ok_in, post_ok_ff;
   logic [RW-1:0]        post_row_in, post_row_ff;
   logic [CW-1:0]        post_col_in, post_col_ff;
   logic [PXW-1:0]       pixel_in;

   logic                 out_valid_ff;
   logic [5:0]           out_row_ff;
   logic [10:0]          out_col_ff;
   logic [16:0]          out_pixel_ff;

   assign busy      = reset;
   assign csr_ready = ~reset;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= lrip_pkg::RST_ROW_COUNT;
         column_count_ff <= lrip_pkg::RST_COLUMN_COUNT;
         angle_top_ff    <= lrip_pkg::RST_ANGLE_TOP;
         angle_bottom_ff <= lrip_pkg::RST_ANGLE_BOTTOM;
         min_range_ff    <= lrip_pkg::RST_MIN_RANGE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lrip_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_data[6:0];
            lrip_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_data[11:0];
            lrip_pkg::CSR_ANGLE_TOP:    angle_top_ff    <= csr_data[14:0];
            lrip_pkg::CSR_ANGLE_BOTTOM: angle_bottom_ff <= csr_data[14:0];
            lrip_pkg::CSR_MIN_RANGE:    min_range_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (row_count_ff < 7'd2) begin
         rows_c = RW'(2);
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         rows_c = RW'(MAX_ROWS);
      end else begin
         rows_c = RW'(row_count_ff);
      end
      if (column_count_ff < 12'd4) begin
         cols_c = CW'(4);
      end else if (int'(column_count_ff) > MAX_COLUMNS) begin
         cols_c = CW'(MAX_COLUMNS);
      end else begin
         cols_c = CW'(column_count_ff);
      end
   end

   assign span = {1'b0, angle_top_ff} + {1'b0, angle_bottom_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[S_OUT-1:1], accept};
      end
   end

   // squares and sums
   always_ff @(posedge clock) begin
      px_ff[S_IN] <= req_point_x;
      py_ff[S_IN] <= req_point_y;
      pz_ff[S_IN] <= req_point_z;
      for (int k = S_IN + 1; k <= S_ROOT; k++) begin
         px_ff[k] <= px_ff[k-1];
         py_ff[k] <= py_ff[k-1];
         pz_ff[k] <= pz_ff[k-1];
      end
      xx_ff   <= 40'(40'(px_ff[S_IN]) * 40'(px_ff[S_IN]));
      yy_ff   <= 40'(40'(py_ff[S_IN]) * 40'(py_ff[S_IN]));
      zz_ff   <= 40'(40'(pz_ff[S_IN]) * 40'(pz_ff[S_IN]));
      hxy_ff  <= xx_ff + yy_ff;
      hxyz_ff <= xx_ff + yy_ff + zz_ff;
   end

   lrip_isqrt u_sqrt_xy (
      .clock    (clock),
      .radicand (hxy_ff),
      .root     (rxy)
   );

   lrip_isqrt u_sqrt_rng (
      .clock    (clock),
      .radicand (hxyz_ff),
      .root     (rng_root)
   );

   always_ff @(posedge clock) begin
      rng_ff[S_CENT] <= rng_root;
      for (int k = S_CENT + 1; k <= S_OUT; k++) begin
         rng_ff[k] <= rng_ff[k-1];
      end
   end

   // CORDIC vectoring: lane 0 elevation, lane 1 azimuth
   always_comb begin
      logic signed [20:0] num [0:1];
      logic signed [20:0] den [0:1];
      logic [20:0]        an;
      logic [20:0]        ad;
      num[0] = 21'(pz_ff[S_ROOT]);
      den[0] = $signed({1'b0, rxy});
      num[1] = 21'(px_ff[S_ROOT]);
      den[1] = 21'(py_ff[S_ROOT]);
      for (int l = 0; l < 2; l++) begin
         an = num[l][20] ? 21'(-num[l]) : num[l];
         ad = den[l][20] ? 21'(-den[l]) : den[l];
         entry[l].x       = {3'b000, ad, 16'h0000};
         entry[l].y       = {3'b000, an, 16'h0000};
         entry[l].z       = '0;
         entry[l].num_neg = num[l][20];
         entry[l].den_neg = den[l][20];
      end
   end

   always_comb begin
      lrip_pkg::cordic_type cp;
      lrip_pkg::cordic_type cn;
      logic signed [39:0]   xs;
      logic signed [39:0]   ys;
      logic signed [24:0]   at;
      for (int l = 0; l < 2; l++) begin
         for (int k = S_CENT; k <= S_CEND; k++) begin
            if (k == S_CENT) begin
               cord_in[l][k] = entry[l];
            end else begin
               cp = cord_ff[l][k-1];
               xs = cp.x >>> (k - S_CENT - 1);
               ys = cp.y >>> (k - S_CENT - 1);
               at = $signed({3'b000, lrip_pkg::atan_entry(k - S_CENT - 1)});
               cn = cp;
               if (cp.y > 0) begin
                  cn.x = cp.x + ys;
                  cn.y = cp.y - xs;
                  cn.z = cp.z + at;
               end else begin
                  cn.x = cp.x - ys;
                  cn.y = cp.y + xs;
                  cn.z = cp.z - at;
               end
               cord_in[l][k] = cn;
            end
         end
      end
   end

   always_comb begin
      logic signed [24:0] zz;
      logic signed [24:0] zc;
      logic signed [24:0] zr;
      logic signed [16:0] ang;
      for (int l = 0; l < 2; l++) begin
         zz = cord_ff[l][S_CEND].z;
         if (zz < 0) begin
            zc = '0;
         end else if (zz > Z_MAX) begin
            zc = Z_MAX;
         end else begin
            zc = zz;
         end
         zr  = zc + 25'sd128;
         ang = $signed({2'b00, zr[22:8]});
         if (cord_ff[l][S_CEND].den_neg) begin
            ang = 17'sd46080 - ang;
         end
         if (cord_ff[l][S_CEND].num_neg) begin
            ang = -ang;
         end
         ang_in[l] = ang;
      end
   end

   always_ff @(posedge clock) begin
      cord_ff <= cord_in;
      ang_ff  <= ang_in;
   end

   // scaled numerators
   always_comb begin
      logic signed [16:0] ed;
      logic signed [17:0] azd;
      logic [RW-1:0]      rm1;
      ed      = ang_ff[0] + $signed({2'b00, angle_bottom_ff});
      azd     = 18'(ang_ff[1]) - 18'sd23040;
      rm1     = rows_c - RW'(1);
      rnum_in = PR'(PR'(ed) * PR'($signed({1'b0, rm1})));
      cnum_in = PC'(PC'(azd) * PC'($signed({1'b0, cols_c})));
      rmag_in = DW'(rnum_ff[PR-1] ? -rnum_ff : rnum_ff);
      cmag_in = DW'(cnum_ff[PC-1] ? -cnum_ff : cnum_ff) + DW'(lrip_pkg::DEG180);
   end

   // divide by 360 degrees as a shift by 11 and a reciprocal multiply by 1/45
   always_comb begin
      logic [17:0] cdn;
      logic [34:0] cprod;
      cdn     = 18'(cmag_ff >> 11);
      cprod   = 35'(cdn) * 35'(COL_RECIP);
      cquo_in = DW'(cprod[34:COL_RECIP_SH]);
   end

   always_ff @(posedge clock) begin
      rnum_ff          <= rnum_in;
      cnum_ff          <= cnum_in;
      rmag_ff          <= rmag_in;
      cmag_ff          <= cmag_in;
      rdiv_ff          <= {1'b0, span};
      rneg_ff[S_DIN]   <= rnum_ff[PR-1];
      cneg_ff[S_DIN]   <= cnum_ff[PC-1];
      den0_ff[S_DIN]   <= (span == 16'd0);
      for (int k = S_DIN + 1; k <= S_DOUT; k++) begin
         rneg_ff[k] <= rneg_ff[k-1];
         cneg_ff[k] <= cneg_ff[k-1];
         den0_ff[k] <= den0_ff[k-1];
      end
      cq_ff[S_DIN + 1] <= cquo_in;
      for (int k = S_DIN + 2; k <= S_DOUT; k++) begin
         cq_ff[k] <= cq_ff[k-1];
      end
   end

   lrip_div #(.N(DW), .D(17)) u_div_row (
      .clock    (clock),
      .dividend (rmag_ff),
      .divisor  (rdiv_ff),
      .quotient (rq)
   );

   assign cq = cq_ff[S_DOUT];

   // cell select and checks
   always_comb begin
      logic signed [CW+2:0] rcol;
      logic signed [CW+2:0] colsx;
      logic signed [CW+2:0] col0;
      logic signed [CW+2:0] col1;
      logic                 row_ok;
      logic                 col_ok;
      logic                 rng_ok;
      row_ok = !den0_ff[S_DOUT] && !(rneg_ff[S_DOUT] && (rq != '0))
               && (rq < DW'(rows_c));
      rcol   = $signed({2'b00, cq[CW:0]});
      if (cneg_ff[S_DOUT]) begin
         rcol = -rcol;
      end
      colsx  = $signed({3'b000, cols_c});
      col0   = $signed({4'b0000, cols_c[CW-1:1]}) - rcol;
      col1   = (col0 >= colsx) ? (col0 - colsx) : col0;
      col_ok = !col1[CW+2] && (col1 < colsx);
      rng_ok = (rng_ff[S_DOUT] >= min_range_ff);
      post_ok_in  = row_ok && col_ok && rng_ok;
      post_row_in = post_ok_in ? rq[RW-1:0] : '0;
      post_col_in = post_ok_in ? col1[CW-1:0] : '0;
      pixel_in    = PXW'(post_col_ff) + PXW'(PXW'(post_row_ff) * PXW'(cols_c));
   end

   always_ff @(posedge clock) begin
      post_ok_ff   <= post_ok_in;
      post_row_ff  <= post_row_in;
      post_col_ff  <= post_col_in;
      out_valid_ff <= post_ok_ff;
      out_row_ff   <= 6'(post_row_ff);
      out_col_ff   <= 11'(post_col_ff);
      out_pixel_ff <= 17'(pixel_in);
   end

   assign rsp_strobe      = vld_ff[S_OUT];
   assign rsp_valid_res   = out_valid_ff;
   assign rsp_row         = out_row_ff;
   assign rsp_column      = out_col_ff;
   assign rsp_range_mm    = rng_ff[S_OUT];
   assign rsp_pixel_index = out_pixel_ff;

endmodule
`default_nettype wire

FILE: design/lrip_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrip_checker
// Port-level timing and result checks of the range image projection.
// ----------------------------------------------------------------------------
module lrip_checker #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 2048
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_valid_res,
   input logic [5:0]  rsp_row,
   input logic [10:0] rsp_column,
   input logic [16:0] rsp_pixel_index
);

   localparam int LAT = lrip_pkg::latency(MAX_ROWS, MAX_COLUMNS);

   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted transaction produced no result at fixed latency");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without a matching accepted transaction");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |->
         (rsp_row == 6'd0 && rsp_column == 11'd0 && rsp_pixel_index == 17'd0))
      else $error("invalid point with nonzero cell fields");

endmodule

bind lidar_range_image_projection_top lrip_checker #(
   .MAX_ROWS    (MAX_ROWS),
   .MAX_COLUMNS (MAX_COLUMNS)
) u_lrip_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_valid_res   (rsp_valid_res),
   .rsp_row         (rsp_row),
   .rsp_column      (rsp_column),
   .rsp_pixel_index (rsp_pixel_index)
);
`default_nettype wire
